FILE: src/smcpwm_pkg.sv
// Package for the slot-allocated multi-channel PWM generator.
// Holds the item codes, status codes, register indexes and the structs
// passed between the top level and the slot table. No dependencies.
package smcpwm_pkg;

    localparam int PIN_W      = 6;
    localparam int DUTY_W     = 16;
    localparam int CNT_W      = 16;
    localparam int LEVELS_W   = 4;
    localparam int OUT_IDX_W  = 2;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CNT_W-1:0]  PRESCALE_RST = 16'd382;
    localparam logic [CNT_W-1:0]  PERIOD_RST   = 16'd255;
    // A wrap raises only slots whose duty exceeds this value.
    localparam logic [DUTY_W-1:0] DUTY_HIGH_MIN = 16'd1;

    localparam logic [CFG_ADDR_W-1:0] REG_PRESCALE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD   = 1'd1;

    typedef enum logic [1:0] {
        FUNC_SET     = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_TICK    = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_SLOT   = 2'd1,
        STATUS_NOT_BOUND = 2'd2
    } t_status;

    // Command from the top level to the slot table for one word.
    typedef struct packed {
        t_func              func;
        logic [PIN_W-1:0]   pin;
        logic [DUTY_W-1:0]  duty;
        logic               advance;
        logic               wrap;
        logic [CNT_W-1:0]   count;
    } t_slot_cmd;

    // Result of one word as seen after the slot table update.
    typedef struct packed {
        logic [LEVELS_W-1:0]  levels;
        logic [OUT_IDX_W-1:0] slot_index;
        t_status              status;
    } t_slot_resp;

endpackage

FILE: src/smcpwm_slots.sv
// Slot table of the multi-channel PWM generator: pin binding, duty and
// output level of each slot, with parallel pin matching and free-slot search.
// Depends on smcpwm_pkg.
module smcpwm_slots #(
    parameter int SLOTS = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  smcpwm_pkg::t_slot_cmd  i_cmd,
    output smcpwm_pkg::t_slot_resp o_resp
);
    import smcpwm_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [PIN_W-1:0]  r_pin  [SLOTS];
    logic [DUTY_W-1:0] r_duty [SLOTS];
    logic [SLOTS-1:0]  r_active;
    logic [SLOTS-1:0]  r_level;
    logic [SLOTS-1:0]  n_active;
    logic [SLOTS-1:0]  n_level;

    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             has_free;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] sel_idx;
    logic             wr_bind;
    logic             wr_duty;
    t_status          status;
    logic [3:0]       idx_wide;
    logic [LEVELS_W-1:0] lv;

    // Lowest-numbered match and lowest-numbered free slot.
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        has_free = 1'b0;
        free_idx = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (r_active[k] && (r_pin[k] == i_cmd.pin)) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(k);
            end
            if (!r_active[k]) begin
                has_free = 1'b1;
                free_idx = IDX_W'(k);
            end
        end
    end

    always_comb begin
        n_active = r_active;
        n_level  = r_level;
        sel_idx  = '0;
        wr_bind  = 1'b0;
        wr_duty  = 1'b0;
        status   = STATUS_OK;
        case (i_cmd.func)
            FUNC_SET: begin
                if (hit) begin
                    sel_idx = hit_idx;
                    wr_duty = 1'b1;
                end else if (has_free) begin
                    sel_idx           = free_idx;
                    wr_bind           = 1'b1;
                    wr_duty           = 1'b1;
                    n_active[sel_idx] = 1'b1;
                end else begin
                    status = STATUS_NO_SLOT;
                end
            end
            FUNC_RELEASE: begin
                if (hit) begin
                    sel_idx           = hit_idx;
                    n_active[sel_idx] = 1'b0;
                    n_level[sel_idx]  = 1'b0;
                end else begin
                    status = STATUS_NOT_BOUND;
                end
            end
            FUNC_TICK: begin
                if (i_cmd.advance) begin
                    for (int k = 0; k < SLOTS; k++) begin
                        if (r_active[k]) begin
                            if (i_cmd.wrap && (r_duty[k] > DUTY_HIGH_MIN)) begin
                                n_level[k] = 1'b1;
                            end else if (i_cmd.count == r_duty[k]) begin
                                n_level[k] = 1'b0;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_level  <= '0;
        end else if (i_en) begin
            r_active <= n_active;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SLOTS; k++) begin
            if (i_en && (sel_idx == IDX_W'(k))) begin
                if (wr_bind) begin
                    r_pin[k] <= i_cmd.pin;
                end
                if (wr_duty) begin
                    r_duty[k] <= i_cmd.duty;
                end
            end
        end
    end

    // Only slots zero to three show in the levels field.
    for (genvar g = 0; g < LEVELS_W; g++) begin : g_lv
        if (g < SLOTS) begin : g_used
            assign lv[g] = n_level[g];
        end else begin : g_none
            assign lv[g] = 1'b0;
        end
    end

    assign idx_wide          = 4'(sel_idx);
    assign o_resp.levels     = lv;
    assign o_resp.slot_index = idx_wide[OUT_IDX_W-1:0];
    assign o_resp.status     = status;

endmodule

FILE: src/slot_allocated_multi_channel_pwm.sv
// Top level of the slot-allocated multi-channel PWM generator: stream ports,
// configuration registers, prescaler and period counter, output register.
// Depends on smcpwm_pkg and smcpwm_slots.
//
//   Channel  | Direction | Handshake                    | Contents
//   s_axis   | in        | s_axis_tvalid/s_axis_tready  | set, release or tick word
//   m_axis   | out       | m_axis_tvalid/m_axis_tready  | levels, slot index, status
//   cfg      | in        | i_cfg_we (no wait)           | prescale, period
//
// A word passes through the input register and then the output register, and
// while the output is not stalled one word can be taken in every cycle. The
// update of the slot table and the counters sits between those two registers
// and is a single pass.
// Reset is synchronous and active low; it empties both registers, deactivates
// all slots, drives all levels low and loads the default prescale and period.
// A stall at the output holds the result; the input register keeps one more
// word, and only then does s_axis_tready drop.
module slot_allocated_multi_channel_pwm #(
    parameter int SLOTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: pin_id [5:0], duty [21:6], zero [23:22]
    input  logic [23:0] s_axis_tdata,
    // tuser: func [1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: levels [3:0], slot_index [5:4], status [7:6]
    output logic [7:0]  m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [smcpwm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);
    import smcpwm_pkg::*;

    logic [CNT_W-1:0]  r_prescale;
    logic [CNT_W-1:0]  r_period;
    logic [CNT_W-1:0]  r_psc_cnt;
    logic [CNT_W-1:0]  r_per_cnt;
    logic [CNT_W-1:0]  n_psc_cnt;
    logic [CNT_W-1:0]  n_per_cnt;

    logic              r_in_valid;
    t_func             r_in_func;
    logic [PIN_W-1:0]  r_in_pin;
    logic [DUTY_W-1:0] r_in_duty;

    logic              r_out_valid;
    logic [7:0]        r_out_data;

    logic              step;
    logic              is_tick;
    logic              advance;
    logic              wrap;
    t_slot_cmd         cmd;
    t_slot_resp        resp;

    // The word in the input register moves on when the output register is
    // empty or is being emptied in this cycle.
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    // The prescaler expires once it has reached the prescale value; the
    // period counter then advances and wraps once it is at the period.
    always_comb begin
        is_tick   = (r_in_func == FUNC_TICK);
        advance   = is_tick && (r_psc_cnt >= r_prescale);
        wrap      = advance && (r_per_cnt >= r_period);
        n_psc_cnt = r_psc_cnt;
        n_per_cnt = r_per_cnt;
        if (is_tick) begin
            n_psc_cnt = advance ? '0 : r_psc_cnt + 1'b1;
        end
        if (advance) begin
            n_per_cnt = wrap ? '0 : r_per_cnt + 1'b1;
        end
    end

    assign cmd.func    = r_in_func;
    assign cmd.pin     = r_in_pin;
    assign cmd.duty    = r_in_duty;
    assign cmd.advance = advance;
    assign cmd.wrap    = wrap;
    assign cmd.count   = n_per_cnt;

    smcpwm_slots #(
        .SLOTS (SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (step),
        .i_cmd   (cmd),
        .o_resp  (resp)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= PRESCALE_RST;
            r_period   <= PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_PRESCALE: r_prescale <= i_cfg_wdata;
                REG_PERIOD:   r_period   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Prescaler and period counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psc_cnt <= '0;
            r_per_cnt <= '0;
        end else if (step) begin
            r_psc_cnt <= n_psc_cnt;
            r_per_cnt <= n_per_cnt;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func <= t_func'(s_axis_tuser);
            r_in_pin  <= s_axis_tdata[PIN_W-1:0];
            r_in_duty <= s_axis_tdata[PIN_W+DUTY_W-1:PIN_W];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= {resp.status, resp.slot_index, resp.levels};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: src/smcpwm_check.sv
// Port-level checker for the slot-allocated multi-channel PWM generator,
// bound to the top level. Depends only on the top level's ports.
module smcpwm_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A refused word never reports a slot.
    a_fail_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[7:6] != 2'b00) |-> m_axis_tdata[5:4] == 2'b00)
        else $error("slot index set on a refused word");

    // A new result follows a word that was accepted and then held in the input register.
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without an accepted word");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind slot_allocated_multi_channel_pwm smcpwm_check u_smcpwm_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: dv/testbench.sv
// Self-checking testbench for slot_allocated_multi_channel_pwm: random and directed
// set, release and tick words, with a word-level model of the slot table and counters.
// Depends on smcpwm_pkg and the RTL top level; it needs no files or arguments.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smcpwm_pkg::*;

    localparam int NUM_SLOTS   = 4;
    localparam int CYCLE_LIMIT = 200000;
    // This margin covers the tail and any pause before a register write.
    localparam int SETTLE_CYCLES = 8;
    // The result count at which the receiver stops taking words for a while. It falls
    // in the middle of a phase, so the sender still has words to offer during the hold.
    localparam int LONG_HOLD_AT     = 250;
    localparam int LONG_HOLD_CYCLES = 60;
    // The input field allows a fourth function code that the block must ignore.
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    // One input word: the function travels in tuser, and pin and duty travel in tdata.
    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  pin;
        logic [15:0] duty;
    } t_pwm_word;

    // One output word, already split into its fields.
    typedef struct {
        logic [3:0] levels;
        logic [1:0] slot;
        logic [1:0] status;
    } t_pwm_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [15:0] i_cfg_wdata   = '0;

    slot_allocated_multi_channel_pwm #(
        .SLOTS(NUM_SLOTS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Model of the block: the slot table, both counters and the two registers.
    // It is advanced once for every word that the block accepts.
    // ------------------------------------------------------------------
    logic [15:0] cfg_prescale = PRESCALE_RST;
    logic [15:0] cfg_period   = PERIOD_RST;
    logic [5:0]  tbl_pin    [NUM_SLOTS];
    logic [15:0] tbl_duty   [NUM_SLOTS];
    bit          tbl_active [NUM_SLOTS];
    bit          tbl_level  [NUM_SLOTS];
    logic [15:0] prescale_cnt = '0;
    logic [15:0] period_cnt   = '0;

    t_pwm_result result_words_due[$];

    // Returns the slot that holds the pin, or -1 when no active slot holds it.
    function automatic int bound_slot(logic [5:0] pin);
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (tbl_active[k] && tbl_pin[k] == pin) return k;
        end
        return -1;
    endfunction

    // A tick moves the prescaler. When the prescaler expires, the period counter also
    // moves, and the slots react to the new count.
    function automatic void pwm_tick();
        bit wrap;
        if (prescale_cnt < cfg_prescale) begin
            prescale_cnt++;
            return;
        end
        prescale_cnt = '0;
        wrap = (period_cnt >= cfg_period);
        period_cnt = wrap ? 16'd0 : period_cnt + 16'd1;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (!tbl_active[k]) continue;
            // A wrap raises the slot, and it takes priority over the compare
            // that lowers it.
            if (wrap && tbl_duty[k] > DUTY_HIGH_MIN) tbl_level[k] = 1'b1;
            else if (period_cnt == tbl_duty[k]) tbl_level[k] = 1'b0;
        end
    endfunction

    // Applies one accepted word to the model and queues the result word that the
    // block must produce for it.
    function automatic void pwm_step(t_pwm_word w);
        t_pwm_result r;
        int s;
        r.slot   = '0;
        r.status = STATUS_OK;
        case (w.func)
            FUNC_SET: begin
                s = bound_slot(w.pin);
                if (s < 0) begin
                    // An unknown pin takes the lowest free slot, if there is one.
                    for (int k = 0; k < NUM_SLOTS; k++) begin
                        if (!tbl_active[k]) begin
                            s = k;
                            break;
                        end
                    end
                    if (s >= 0) begin
                        tbl_active[s] = 1'b1;
                        tbl_pin[s]    = w.pin;
                    end
                end
                if (s >= 0) begin
                    tbl_duty[s] = w.duty;
                    r.slot      = s[1:0];
                end else begin
                    r.status = STATUS_NO_SLOT;
                end
            end
            FUNC_RELEASE: begin
                s = bound_slot(w.pin);
                if (s >= 0) begin
                    tbl_active[s] = 1'b0;
                    tbl_level[s]  = 1'b0;
                    tbl_pin[s]    = '0;
                    tbl_duty[s]   = '0;
                    r.slot        = s[1:0];
                end else begin
                    r.status = STATUS_NOT_BOUND;
                end
            end
            FUNC_TICK: pwm_tick();
            default: ;  // the spare code changes nothing
        endcase
        for (int k = 0; k < 4; k++) r.levels[k] = (k < NUM_SLOTS) ? tbl_level[k] : 1'b0;
        result_words_due.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Sender. Words come from a queue that the initial block fills. After each word is
    // accepted, the sender may pause before it offers the next one, if sender_idles is set.
    // ------------------------------------------------------------------
    t_pwm_word words_to_send[$];
    t_pwm_word word_on_bus;
    int        words_queued   = 0;
    int        words_accepted = 0;
    int        send_gap       = 0;
    bit        sender_idles   = 1'b0;
    bit        receiver_idles = 1'b0;

    always @(posedge i_clk) begin : sender
        bit taken;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            taken = s_axis_tvalid && s_axis_tready;
            if (taken) begin
                pwm_step(word_on_bus);
                words_accepted++;
                send_gap = sender_idles ? $urandom_range(0, 3) : 0;
            end
            // Valid gets one assignment per edge. When the next word is ready, valid
            // stays high and is never lowered and raised in the same step.
            if (!s_axis_tvalid || taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (words_to_send.size() > 0) begin
                    word_on_bus = words_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, word_on_bus.duty, word_on_bus.pin};
                    s_axis_tuser  <= word_on_bus.func;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver and checker. Every accepted result word is compared field by field
    // with the oldest result that is due. Once, at a fixed result count, the receiver
    // holds off for a long stretch. This lets the output and input registers fill up
    // and makes s_axis_tready drop.
    // ------------------------------------------------------------------
    int fail_count   = 0;
    int results_seen = 0;
    int hold_left    = 0;

    task automatic compare_field(string field, int want, int got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : receiver
        t_pwm_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (result_words_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: result word with none due, expected nothing, actual %h",
                             $time, m_axis_tdata);
                end else begin
                    want = result_words_due.pop_front();
                    compare_field("levels", want.levels, m_axis_tdata[3:0]);
                    compare_field("slot_index", want.slot, m_axis_tdata[5:4]);
                    compare_field("status", want.status, m_axis_tdata[7:6]);
                end
                if (results_seen == LONG_HOLD_AT) hold_left = LONG_HOLD_CYCLES;
                else hold_left = receiver_idles ? $urandom_range(0, 3) : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // A hung handshake ends the run here.
    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_word(logic [1:0] func, logic [5:0] pin, logic [15:0] duty);
        t_pwm_word w;
        w.func = func;
        w.pin  = pin;
        w.duty = duty;
        words_to_send.push_back(w);
        words_queued++;
    endfunction

    // Waits until every queued word has been taken and every result word has come back.
    // The block is then idle, with both pipeline registers empty, and a short pause follows.
    task automatic wait_until_drained();
        while (words_accepted != words_queued || result_words_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The model takes the new value as the write is driven, before the block registers
    // it. The block is idle, so no word sees the value in between.
    task automatic write_register(logic [CFG_ADDR_W-1:0] addr, logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        if (addr == REG_PRESCALE) cfg_prescale = value;
        else cfg_period = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // A random phase. Most words use a small pool of pins. With more pins than slots,
    // sets get refused and releases miss as well as hit. Duties mostly fall inside the
    // current period, so the compares actually fire.
    task automatic queue_random_phase(int count);
        logic [5:0]  pool[6];
        logic [1:0]  func;
        logic [5:0]  pin;
        logic [15:0] duty;
        int          pick;
        int          span;
        foreach (pool[i]) pool[i] = 6'($urandom_range(0, 63));
        span = (int'(cfg_period) + 2 > 65535) ? 65535 : int'(cfg_period) + 2;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) func = FUNC_TICK;
            else if (pick < 75) func = FUNC_SET;
            else if (pick < 95) func = FUNC_RELEASE;
            else func = FUNC_SPARE;
            pin = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                              : pool[$urandom_range(0, 5)];
            pick = $urandom_range(0, 9);
            if (pick < 7) duty = 16'($urandom_range(0, span));
            else if (pick < 9) duty = 16'($urandom_range(0, 65535));
            else duty = 16'($urandom_range(0, 2));
            queue_word(func, pin, duty);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    logic [15:0] phase_prescale[8] = '{16'd0, 16'd1, 16'd65535, 16'd0,
                                       16'd2, 16'd0, 16'd3, 16'd1};
    logic [15:0] phase_period[8]   = '{16'd1, 16'd7, 16'd1, 16'd65535,
                                       16'd13, 16'd2, 16'd30, 16'd5};

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A short random run at the reset values, before any register is written.
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        queue_random_phase(40);
        wait_until_drained();

        // Directed words with a fast prescaler and a short period. All four slots get
        // filled with duties 0, maximum, 1 and a normal value. A fifth pin is refused.
        // A bound pin gets a new duty. A release frees a middle slot, a second release
        // of the same pin misses, and the freed slot is then reused.
        write_register(REG_PRESCALE, 16'd0);
        write_register(REG_PERIOD, 16'd4);
        queue_word(FUNC_SET, 6'd0, 16'h0000);
        queue_word(FUNC_SET, 6'd63, 16'hFFFF);
        queue_word(FUNC_SET, 6'd21, 16'd1);
        queue_word(FUNC_SET, 6'd42, 16'd3);
        queue_word(FUNC_SET, 6'd5, 16'd2);
        queue_word(FUNC_SET, 6'd42, 16'd2);
        repeat (6) queue_word(FUNC_TICK, 6'd63, 16'hFFFF);
        queue_word(FUNC_RELEASE, 6'd21, 16'd0);
        queue_word(FUNC_RELEASE, 6'd21, 16'd0);
        queue_word(FUNC_SET, 6'd5, 16'd2);
        queue_word(FUNC_SPARE, 6'd63, 16'hFFFF);
        queue_word(FUNC_RELEASE, 6'd0, 16'd0);
        repeat (4) queue_word(FUNC_TICK, 6'd0, 16'h0000);
        queue_word(FUNC_RELEASE, 6'd63, 16'd0);
        wait_until_drained();

        // Random phases across register settings that include both extremes of the
        // prescale and the maximum period. Idling on each side is switched on or off
        // per phase, so some stretches run at full rate.
        foreach (phase_prescale[p]) begin
            write_register(REG_PRESCALE, phase_prescale[p]);
            write_register(REG_PERIOD, phase_period[p]);
            sender_idles   = (p % 3 != 0);
            receiver_idles = (p % 4 != 1);
            queue_random_phase(120);
            wait_until_drained();
        end

        if (fail_count == 0 && result_words_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: slot_allocated_multi_channel_pwm.f
src/smcpwm_pkg.sv
src/smcpwm_slots.sv
src/slot_allocated_multi_channel_pwm.sv
src/smcpwm_check.sv
dv/testbench.sv
